>>> sv/p1td_pkg.sv
// ----------------------------------------------------------------------------
// p1td_pkg: shared types and constants of the P1 telegram deframer
// Phase codes, result kinds, framing characters and the result batch
// that travels from the framing engine to the result serializer.
// ----------------------------------------------------------------------------
package p1td_pkg;

   localparam int unsigned CountWidth = 14;
   localparam int unsigned HeldDepth  = 6;
   localparam int unsigned BatchDepth = 7;

   // hard ceiling on the frame byte count, whatever the register says
   localparam logic [CountWidth-1:0] MAX_FRAME_BYTES = 14'd8192;
   localparam logic [CountWidth-1:0] CFG_RESET       = 14'd1500;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam logic [1:0] KIND_BODY     = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_SEP,
      PH_BODY,
      PH_FOOT,
      PH_DONE
   } phase_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic                           valid;
      logic [1:0]                     kind;
      logic [2:0]                     count;   // number of results, 1 to 7
      logic [BatchDepth-1:0][7:0]     bytes;   // body bytes, first in entry 0
      logic [31:0]                    code;
      logic [CountWidth-1:0]          blen;
      logic [CountWidth-1:0]          hlen;
   } batch_type;

endpackage

>>> sv/p1td_engine.sv
// ----------------------------------------------------------------------------
// p1td_engine: framing state and single-pass byte processing
// Holds the phase, the counters and the held footer candidate, and turns
// each accepted transaction into a batch of results in the same cycle.
// ----------------------------------------------------------------------------
module p1td_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic                               is_gap,
   input  logic [7:0]                         data_byte,
   input  logic                               csr_wr_en,
   input  logic [p1td_pkg::CountWidth-1:0]    csr_wr_data,
   output p1td_pkg::batch_type                batch
);

   p1td_pkg::phase_type                        phase_ff, phase_in;
   logic [p1td_pkg::CountWidth-1:0]            cfg_ff;
   logic [p1td_pkg::CountWidth-1:0]            frame_ff, frame_in;
   logic [p1td_pkg::CountWidth-1:0]            body_ff, body_in;
   logic [p1td_pkg::CountWidth-1:0]            prefix_ff, prefix_in;
   logic                                       cr_ff, cr_in;
   logic [2:0]                                 hc_ff, hc_in;
   logic [p1td_pkg::HeldDepth-1:0][7:0]        held_ff, held_in;
   logic [p1td_pkg::CountWidth-1:0]            limit;
   logic                                       over;

   assign limit = (cfg_ff > p1td_pkg::MAX_FRAME_BYTES) ? p1td_pkg::MAX_FRAME_BYTES : cfg_ff;
   assign over  = (frame_ff >= limit);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (is_gap) begin
            phase_in = p1td_pkg::PH_HUNT;
         end else begin
            unique case (phase_ff) inside
               p1td_pkg::PH_HUNT: begin
                  if (data_byte == p1td_pkg::CHAR_SLASH) phase_in = p1td_pkg::PH_HEADER;
               end
               p1td_pkg::PH_HEADER, p1td_pkg::PH_SEP: begin
                  if (over) begin
                     phase_in = p1td_pkg::PH_DONE;
                  end else if (cr_ff && data_byte == p1td_pkg::CHAR_LF) begin
                     phase_in = (phase_ff == p1td_pkg::PH_HEADER) ? p1td_pkg::PH_SEP
                                                                  : p1td_pkg::PH_BODY;
                  end
               end
               p1td_pkg::PH_BODY: begin
                  if (over) begin
                     phase_in = p1td_pkg::PH_DONE;
                  end else if (data_byte == p1td_pkg::CHAR_BANG) begin
                     phase_in = p1td_pkg::PH_FOOT;
                  end
               end
               p1td_pkg::PH_FOOT: begin
                  if (over) begin
                     phase_in = p1td_pkg::PH_DONE;
                  end else if (hc_ff == 3'd5) begin
                     if (data_byte != p1td_pkg::CHAR_CR) phase_in = p1td_pkg::PH_BODY;
                  end else if (hc_ff >= 3'd6) begin
                     phase_in = (data_byte == p1td_pkg::CHAR_LF) ? p1td_pkg::PH_DONE
                                                                 : p1td_pkg::PH_BODY;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // counters, held candidate and result batch
   always_comb begin
      frame_in  = frame_ff;
      body_in   = body_ff;
      prefix_in = prefix_ff;
      cr_in     = cr_ff;
      hc_in     = hc_ff;
      held_in   = held_ff;
      batch     = '0;
      if (fire) begin
         if (is_gap) begin
            frame_in  = '0;
            body_in   = '0;
            prefix_in = '0;
            cr_in     = 1'b0;
            hc_in     = '0;
         end else begin
            unique case (phase_ff) inside
               p1td_pkg::PH_HUNT: begin
                  if (data_byte == p1td_pkg::CHAR_SLASH) begin
                     frame_in  = 14'd1;
                     body_in   = '0;
                     prefix_in = '0;
                     cr_in     = 1'b0;
                     hc_in     = '0;
                  end
               end
               p1td_pkg::PH_HEADER, p1td_pkg::PH_SEP, p1td_pkg::PH_BODY,
               p1td_pkg::PH_FOOT: begin
                  if (over) begin
                     batch.valid = 1'b1;
                     batch.kind  = p1td_pkg::KIND_OVERFLOW;
                     batch.count = 3'd1;
                     frame_in    = '0;
                     body_in     = '0;
                     prefix_in   = '0;
                     cr_in       = 1'b0;
                     hc_in       = '0;
                  end else begin
                     frame_in = frame_ff + 14'd1;
                     if (phase_ff == p1td_pkg::PH_HEADER || phase_ff == p1td_pkg::PH_SEP) begin
                        if (cr_ff) begin
                           cr_in = 1'b0;
                           if (data_byte == p1td_pkg::CHAR_LF &&
                               phase_ff == p1td_pkg::PH_SEP) begin
                              prefix_in = frame_ff + 14'd1;
                           end
                        end else if (data_byte == p1td_pkg::CHAR_CR) begin
                           cr_in = 1'b1;
                        end
                     end else if (phase_ff == p1td_pkg::PH_BODY) begin
                        if (data_byte == p1td_pkg::CHAR_BANG) begin
                           held_in[0] = data_byte;
                           hc_in      = 3'd1;
                        end else begin
                           batch.valid    = 1'b1;
                           batch.kind     = p1td_pkg::KIND_BODY;
                           batch.count    = 3'd1;
                           batch.bytes[0] = data_byte;
                           body_in        = body_ff + 14'd1;
                        end
                     end else begin
                        if (hc_ff < 3'd5) begin
                           held_in[hc_ff] = data_byte;
                           hc_in          = hc_ff + 3'd1;
                        end else if (hc_ff == 3'd5) begin
                           if (data_byte == p1td_pkg::CHAR_CR) begin
                              held_in[5] = data_byte;
                              hc_in      = 3'd6;
                           end else begin
                              // false footer: release '!', four chars and this byte
                              batch.valid = 1'b1;
                              batch.kind  = p1td_pkg::KIND_BODY;
                              batch.count = 3'd6;
                              for (int i = 0; i < 5; i++) batch.bytes[i] = held_ff[i];
                              batch.bytes[5] = data_byte;
                              body_in        = body_ff + 14'd6;
                              hc_in          = '0;
                           end
                        end else begin
                           if (data_byte == p1td_pkg::CHAR_LF) begin
                              batch.valid = 1'b1;
                              batch.kind  = p1td_pkg::KIND_COMPLETE;
                              batch.count = 3'd1;
                              batch.code  = {held_ff[1], held_ff[2], held_ff[3], held_ff[4]};
                              batch.blen  = body_ff;
                              batch.hlen  = prefix_ff;
                              frame_in    = '0;
                              body_in     = '0;
                              prefix_in   = '0;
                              cr_in       = 1'b0;
                              hc_in       = '0;
                           end else begin
                              // CR without LF: release all six held bytes and this one
                              batch.valid = 1'b1;
                              batch.kind  = p1td_pkg::KIND_BODY;
                              batch.count = 3'd7;
                              for (int i = 0; i < 6; i++) batch.bytes[i] = held_ff[i];
                              batch.bytes[6] = data_byte;
                              body_in        = body_ff + 14'd7;
                              hc_in          = '0;
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= p1td_pkg::PH_HUNT;
         cfg_ff    <= p1td_pkg::CFG_RESET;
         frame_ff  <= '0;
         body_ff   <= '0;
         prefix_ff <= '0;
         cr_ff     <= 1'b0;
         hc_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         frame_ff  <= frame_in;
         body_ff   <= body_in;
         prefix_ff <= prefix_in;
         cr_ff     <= cr_in;
         hc_ff     <= hc_in;
         if (csr_wr_en) cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

>>> sv/p1td_serializer.sv
// ----------------------------------------------------------------------------
// p1td_serializer: result batch register and output sequencing
// Holds one batch and hands its results out one transaction at a time.
// ----------------------------------------------------------------------------
module p1td_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  p1td_pkg::batch_type   batch,
   output logic                  slot_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   p1td_pkg::batch_type   batch_ff;
   logic                  valid_ff;
   logic [2:0]            idx_ff;
   logic                  take;

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = (idx_ff == batch_ff.count - 3'd1);
   assign take       = valid_ff && rsp_tready;
   assign slot_free  = !valid_ff || (rsp_tready && rsp_tlast);

   assign rsp_tuser  = batch_ff.kind;
   assign rsp_tdata  = {4'b0000, batch_ff.hlen, batch_ff.blen, batch_ff.code,
                        batch_ff.bytes[idx_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (batch.valid) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (rsp_tlast) begin
            valid_ff <= 1'b0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (batch.valid) batch_ff <= batch;
   end

endmodule

>>> sv/p1_telegram_deframer.sv
// ----------------------------------------------------------------------------
// p1_telegram_deframer: frames meter-link telegrams from a byte stream
// Hunts for '/', skips the header and separator lines, streams body bytes
// and reports a '!' footer with its check code and the frame lengths.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per received byte (req_tuser = 0) or receive
//            gap (req_tuser = 1). A gap drops any frame and rearms the hunt.
//   rsp_*  : body bytes, frame-complete and overflow-discard results; one
//            input transaction causes zero to seven results, rsp_tlast marks
//            the final one.
//   csr_*  : max_frame_bytes, written while the block is idle.
// Output: results of a transaction are registered and appear in the cycle after it is accepted.
// Throughput: one transaction per cycle while each causes at most one
//   result and rsp_tready stays high; a transaction causing several results
//   occupies the result register until the single output port drains the batch.
// Reset: synchronous; clears the phase to hunting, the counters and the
//   result register, and loads max_frame_bytes with 1500.
// Stall: while rsp_tready is low the batch holds and req_tready drops
//   once the batch cannot be finished; the next transaction is taken in the
//   same cycle the final result of the batch leaves.
// ----------------------------------------------------------------------------
module p1_telegram_deframer (
   input  logic          clock,
   input  logic          reset,
   // input channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic [0:0]    req_tuser,   // [0] command: 0 byte, 1 receive gap
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata,   // [7:0] body_byte, [39:8] footer_code,
                                      // [53:40] body_length, [67:54] header_length
   output logic [1:0]    rsp_tuser,   // [1:0] result_kind
   output logic          rsp_tlast,   // last
   // configuration
   input  logic          csr_wr_en,
   input  logic [13:0]   csr_wr_data  // max_frame_bytes
);

   p1td_pkg::batch_type   batch;
   logic                  slot_free;
   logic                  fire;

   // take a new transaction whenever the result register is free or empties now
   assign req_tready = slot_free;
   assign fire       = req_tvalid && req_tready;

   p1td_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .is_gap      (req_tuser[0]),
      .data_byte   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .batch       (batch)
   );

   p1td_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // hold off input while a batch is pending and its last result is not leaving
   a_no_accept_over_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !(rsp_tready && rsp_tlast) |-> !req_tready)
      else $error("input accepted over a pending result batch");

   // frame-complete and overflow results are single and always last
   a_single_result_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != p1td_pkg::KIND_BODY |-> rsp_tlast)
      else $error("non-body result not marked last");

   // a receive gap never produces a result
   a_gap_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=>
         rsp_tvalid == $past(rsp_tvalid && !(rsp_tready && rsp_tlast)))
      else $error("receive gap produced a result");

   // body results carry no footer code or lengths
   a_body_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == p1td_pkg::KIND_BODY |-> rsp_tdata[71:8] == 64'd0)
      else $error("body result carries footer fields");

endmodule

>>> tb/p1_telegram_deframer_test.sv
// ----------------------------------------------------------------------------
// p1_telegram_deframer_test: self-checking bench of the P1 telegram deframer
// Streams meter-link bytes and receive gaps into the block, predicts the body
// bytes, frame-complete and overflow results with a model kept in the bench,
// and checks every result transaction against it under random back-pressure.
// ----------------------------------------------------------------------------
module p1_telegram_deframer_test;

   // one input transaction: a received byte or a receive gap
   typedef struct packed {
      logic       gap;
      logic [7:0] data;
   } link_item_type;

   // one predicted result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [31:0] code;
      logic [13:0] blen;
      logic [13:0] hlen;
      logic        last;
   } frame_result_type;

   localparam int WatchdogCycles = 3000;
   localparam int LongStallCycles = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] command: 0 byte, 1 receive gap
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // [7:0] body_byte, [39:8] footer_code,
                                     // [53:40] body_length, [67:54] header_length
   logic [1:0]  rsp_tuser;           // [1:0] result_kind
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [13:0] csr_wr_data = 14'd0;

   // stimulus and scoreboard storage
   link_item_type    link_items[$];
   frame_result_type frame_results_due[$];
   int               items_sent = 0;
   int               mismatch_count = 0;
   bit               req_fired = 1'b0;

   // idling knobs, changed by the stimulus sequence
   int send_idle_pct = 21;
   int recv_idle_pct = 88;

   // long receiver hold-off: toggle stall_go to start one
   bit stall_go = 1'b0;
   bit stall_seen = 1'b0;
   int stall_left = 0;

   // bench copy of the deframer state
   logic [13:0]          frame_limit_reg;
   p1td_pkg::phase_type  fr_phase;
   logic [7:0]           held_chars [0:5];
   int                   held_n;
   int                   frame_cnt;
   int                   body_cnt;
   int                   prefix_cnt;
   bit                   cr_pending;
   frame_result_type     tail_result;
   bit                   have_tail;

   int idle_cycles = 0;

   p1_telegram_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Deframing prediction
   // ------------------------------------------------------------------------

   task automatic clear_frame_state();
      for (int i = 0; i < 6; i++) held_chars[i] = 8'h00;
      held_n = 0;
      frame_cnt = 0;
      body_cnt = 0;
      prefix_cnt = 0;
      cr_pending = 1'b0;
   endtask

   // Queue the previous result and keep this one back, so that the final
   // result of a transaction can still be marked as last.
   task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                       input logic [31:0] code, input logic [13:0] blen,
                       input logic [13:0] hlen);
      if (have_tail) frame_results_due.push_back(tail_result);
      tail_result.kind = kind;
      tail_result.data = data;
      tail_result.code = code;
      tail_result.blen = blen;
      tail_result.hlen = hlen;
      tail_result.last = 1'b0;
      have_tail = 1'b1;
   endtask

   task automatic emit_body(input logic [7:0] b);
      emit(p1td_pkg::KIND_BODY, b, 32'd0, 14'd0, 14'd0);
      body_cnt++;
   endtask

   task automatic deframe_step(input logic is_gap, input logic [7:0] b);
      int lim;
      lim = (frame_limit_reg > p1td_pkg::MAX_FRAME_BYTES) ? int'(p1td_pkg::MAX_FRAME_BYTES)
                                                          : int'(frame_limit_reg);
      if (is_gap) begin
         // a gap drops any frame silently and rearms the hunt
         fr_phase = p1td_pkg::PH_HUNT;
         clear_frame_state();
      end else if (fr_phase == p1td_pkg::PH_HUNT) begin
         if (b == p1td_pkg::CHAR_SLASH) begin
            clear_frame_state();
            frame_cnt = 1;
            fr_phase = p1td_pkg::PH_HEADER;
         end
      end else if (fr_phase == p1td_pkg::PH_DONE) begin
         // ignore everything until the next gap
      end else if (frame_cnt >= lim) begin
         emit(p1td_pkg::KIND_OVERFLOW, 8'h00, 32'd0, 14'd0, 14'd0);
         clear_frame_state();
         fr_phase = p1td_pkg::PH_DONE;
      end else begin
         frame_cnt++;
         case (fr_phase)
            p1td_pkg::PH_HEADER, p1td_pkg::PH_SEP: begin
               // the byte after a CR always belongs to the line
               if (cr_pending) begin
                  cr_pending = 1'b0;
                  if (b == p1td_pkg::CHAR_LF) begin
                     if (fr_phase == p1td_pkg::PH_HEADER) begin
                        fr_phase = p1td_pkg::PH_SEP;
                     end else begin
                        prefix_cnt = frame_cnt;
                        fr_phase = p1td_pkg::PH_BODY;
                     end
                  end
               end else if (b == p1td_pkg::CHAR_CR) begin
                  cr_pending = 1'b1;
               end
            end
            p1td_pkg::PH_BODY: begin
               if (b == p1td_pkg::CHAR_BANG) begin
                  held_chars[0] = b;
                  held_n = 1;
                  fr_phase = p1td_pkg::PH_FOOT;
               end else begin
                  emit_body(b);
               end
            end
            p1td_pkg::PH_FOOT: begin
               if (held_n < 5) begin
                  held_chars[held_n] = b;
                  held_n++;
               end else if (held_n == 5) begin
                  if (b == p1td_pkg::CHAR_CR) begin
                     held_chars[5] = b;
                     held_n = 6;
                  end else begin
                     // no CR after the check chars: release six bytes
                     for (int i = 0; i < 5; i++) emit_body(held_chars[i]);
                     emit_body(b);
                     held_n = 0;
                     fr_phase = p1td_pkg::PH_BODY;
                  end
               end else begin
                  if (b == p1td_pkg::CHAR_LF) begin
                     emit(p1td_pkg::KIND_COMPLETE, 8'h00,
                          {held_chars[1], held_chars[2], held_chars[3], held_chars[4]},
                          14'(body_cnt), 14'(prefix_cnt));
                     clear_frame_state();
                     fr_phase = p1td_pkg::PH_DONE;
                  end else begin
                     // CR without LF: release seven bytes, skip nothing
                     for (int i = 0; i < 6; i++) emit_body(held_chars[i]);
                     emit_body(b);
                     held_n = 0;
                     fr_phase = p1td_pkg::PH_BODY;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (have_tail) begin
         tail_result.last = 1'b1;
         frame_results_due.push_back(tail_result);
         have_tail = 1'b0;
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: sample at the rising edge, check results, then predict
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      frame_result_type due;
      if (reset) begin
         frame_limit_reg = p1td_pkg::CFG_RESET;
         fr_phase = p1td_pkg::PH_HUNT;
         clear_frame_state();
         have_tail = 1'b0;
         req_fired <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               due = frame_results_due.pop_front();
               compare_field("result_kind", 32'(due.kind), 32'(rsp_tuser));
               compare_field("body_byte", 32'(due.data), 32'(rsp_tdata[7:0]));
               compare_field("footer_code", due.code, rsp_tdata[39:8]);
               compare_field("body_length", 32'(due.blen), 32'(rsp_tdata[53:40]));
               compare_field("header_length", 32'(due.hlen), 32'(rsp_tdata[67:54]));
               compare_field("last", 32'(due.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) deframe_step(req_tuser[0], req_tdata);
         if (csr_wr_en) frame_limit_reg = csr_wr_data;
         req_fired <= req_tvalid && req_tready;
      end
   end

   // ------------------------------------------------------------------------
   // Driver: advance at the falling edge once the held transaction is taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      link_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = link_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data;
            req_tuser  <= item.gap;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (stall_go != stall_seen) begin
         stall_seen <= stall_go;
         stall_left <= LongStallCycles;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogCycles) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, WatchdogCycles);
         $display("** p1_telegram_deframer: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic send(input logic [7:0] b);
      link_item_type item;
      item.gap = 1'b0;
      item.data = b;
      link_items.push_back(item);
      items_sent++;
   endtask

   task automatic send_gap();
      link_item_type item;
      item.gap = 1'b1;
      item.data = 8'($urandom_range(255));
      link_items.push_back(item);
      items_sent++;
   endtask

   // mostly printable text, sometimes any byte
   function automatic logic [7:0] pick_char();
      if ($urandom_range(4) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(8'h7E, 8'h20));
   endfunction

   // '!' with four check chars that then breaks off, with or without CR
   task automatic send_false_footer();
      logic [7:0] b;
      send(p1td_pkg::CHAR_BANG);
      repeat (4) send(pick_char());
      b = 8'($urandom_range(255));
      if ($urandom_range(1) == 0) begin
         if (b == p1td_pkg::CHAR_CR) b = p1td_pkg::CHAR_BANG;
         send(b);
      end else begin
         send(p1td_pkg::CHAR_CR);
         if (b == p1td_pkg::CHAR_LF) b = p1td_pkg::CHAR_CR;
         send(b);
      end
   endtask

   // one telegram with random content; most end in a proper footer
   task automatic send_telegram(input int body_min, input int body_max);
      int shape;
      repeat ($urandom_range(2)) send(8'($urandom_range(255)));
      send(p1td_pkg::CHAR_SLASH);
      repeat ($urandom_range(10, 1)) send(pick_char());
      if ($urandom_range(3) == 0) begin
         send(p1td_pkg::CHAR_CR);
         send(pick_char());
      end
      send(p1td_pkg::CHAR_CR);
      send(p1td_pkg::CHAR_LF);
      repeat ($urandom_range(2)) send(pick_char());
      send(p1td_pkg::CHAR_CR);
      send(p1td_pkg::CHAR_LF);
      repeat ($urandom_range(body_max, body_min)) begin
         if ($urandom_range(11) == 0) send_false_footer();
         else send(pick_char());
      end
      shape = $urandom_range(9);
      if (shape < 8) begin
         send(p1td_pkg::CHAR_BANG);
         repeat (4) send(8'($urandom_range(255)));
         send(p1td_pkg::CHAR_CR);
         send(p1td_pkg::CHAR_LF);
         repeat ($urandom_range(2)) send(pick_char());
      end else if (shape == 8) begin
         // cut off inside the footer
         send(p1td_pkg::CHAR_BANG);
         repeat ($urandom_range(5)) send(pick_char());
      end
      send_gap();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(6, 1)) begin
         if ($urandom_range(3) == 0) send_gap();
         else send(8'($urandom_range(255)));
      end
   endtask

   task automatic send_random_until(input int target);
      while (items_sent < target) begin
         if ($urandom_range(7) == 0) send_noise();
         else if ($urandom_range(9) == 0) send_telegram(13, 40);
         else send_telegram(0, 12);
      end
   endtask

   // wait until every transaction is taken and every result has come back
   task automatic wait_until_quiet();
      while (link_items.size() != 0 || req_tvalid || frame_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_frame_limit(input logic [13:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_tiny_frames();
      send(p1td_pkg::CHAR_SLASH);
      send(8'h41);
      send(8'h42);
      send_gap();
      send(p1td_pkg::CHAR_SLASH);
      send_gap();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed telegram at the reset limit: junk in the hunt, a swallowed
      // byte after CR, slash in the body, both kinds of false footer, a held
      // '!' released as plain data, a full footer, then trailing bytes
      send(8'hFF);
      send(p1td_pkg::CHAR_BANG);
      send(p1td_pkg::CHAR_SLASH);
      send(8'h41);
      send(p1td_pkg::CHAR_CR);
      send(8'h58);
      send(p1td_pkg::CHAR_CR);
      send(p1td_pkg::CHAR_LF);
      send(p1td_pkg::CHAR_CR);
      send(p1td_pkg::CHAR_LF);
      send(8'h00);
      send(8'hFF);
      send(p1td_pkg::CHAR_SLASH);
      send(p1td_pkg::CHAR_BANG);
      send(8'h61); send(8'h62); send(8'h63); send(8'h64);
      send(8'h5A);
      send(p1td_pkg::CHAR_BANG);
      send(p1td_pkg::CHAR_BANG); send(8'h31); send(8'h32); send(8'h33);
      send(p1td_pkg::CHAR_CR);
      send(8'h71);
      send(p1td_pkg::CHAR_BANG);
      send(8'h57); send(8'h58); send(8'h59); send(8'h5A);
      send(p1td_pkg::CHAR_CR);
      send(p1td_pkg::CHAR_LF);
      send(8'h78);
      send_gap();
      // frame dropped by a gap before its header ends
      send(p1td_pkg::CHAR_SLASH);
      send(8'h68);
      send_gap();
      wait_until_quiet();

      // smallest sensible limit: many frames overflow
      write_frame_limit(14'd16);
      send_random_until(170);
      wait_until_quiet();

      // limits below two: the byte after '/' overflows
      write_frame_limit(14'd1);
      send_tiny_frames();
      wait_until_quiet();
      write_frame_limit(14'd0);
      send_tiny_frames();
      wait_until_quiet();

      // register above the hard ceiling
      send_idle_pct = 88;
      recv_idle_pct = 21;
      write_frame_limit(14'h3FFF);
      send_random_until(320);
      wait_until_quiet();

      // no idling; hold off the receiver while a long frame keeps coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_frame_limit(14'd8192);
      stall_go = ~stall_go;
      send_telegram(50, 60);
      send_random_until(460);
      wait_until_quiet();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && frame_results_due.size() == 0) begin
         $display("** p1_telegram_deframer: PASSED **");
      end else begin
         if (frame_results_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     frame_results_due.size());
         $display("** p1_telegram_deframer: FAILED **");
      end
      $finish;
   end

endmodule
